[rtl/core/psi_pkg.sv]
// Shared types and defaults for the point-in-shape test unit.
package psi_pkg;

  localparam int MaxVertices = 64;

  typedef struct packed {
    logic signed [23:0] dx;
    logic signed [23:0] dy;
  } vertex_t;

  typedef struct packed {
    logic    valid;
    logic    circle;
    vertex_t vi;
    vertex_t vj;
  } edge_req_t;

endpackage

[rtl/core/psi_if.sv]
// Command and result channel interfaces of the point-in-shape test unit.
interface psi_cmd_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [5:0]         vertex_index;
  logic signed [23:0] vertex_dx;
  logic signed [23:0] vertex_dy;
  logic signed [15:0] query_x;
  logic signed [15:0] query_y;

  modport source (
    output valid, op, vertex_index, vertex_dx, vertex_dy, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, op, vertex_index, vertex_dx, vertex_dy, query_x, query_y,
    output ready
  );
endinterface

interface psi_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );
  modport sink (
    input  valid, inside_res,
    output ready
  );
endinterface

[rtl/core/psi_cell.sv]
// One vertex cell of the rotating vertex ring.
module psi_cell (
  input  logic             clk,
  input  logic             load,
  input  psi_pkg::vertex_t load_val,
  input  logic             shift,
  input  psi_pkg::vertex_t shift_in,
  output psi_pkg::vertex_t val
);

  always_ff @(posedge clk) begin
    if (load) begin
      val <= load_val;
    end else if (shift) begin
      val <= shift_in;
    end
  end

endmodule

[rtl/core/psi_edge_unit.sv]
// Pipelined edge crossing and circle distance evaluator with parity accumulator.
module psi_edge_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  psi_pkg::edge_req_t  req,
  input  logic signed [23:0]  px,
  input  logic signed [23:0]  py,
  input  logic signed [23:0]  cx,
  input  logic signed [23:0]  cy,
  input  logic [22:0]         radius,
  output logic                busy,
  output logic                in_shape
);

  logic               v1, circ1;
  logic signed [24:0] xi1, yi1, xj1, yj1;

  logic               v2, circ2, cross2;
  logic signed [25:0] a2, b2, c2, d2;

  logic               v3, circ3, cross3, dpos3;
  logic signed [51:0] lhs3, rhs3;
  logic [45:0]        rr3;

  logic signed [25:0] a_next, b_next, c_next, d_next;
  logic               cross_next;
  logic signed [25:0] px26, py26, cx26, cy26;
  logic signed [24:0] py25;
  logic signed [52:0] sq_sum;
  logic               in_circle, hit;

  // stage 1: absolute vertex coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= req.valid;
    end
    circ1 <= req.circle;
    xi1   <= $signed({req.vi.dx[23], req.vi.dx}) + $signed({cx[23], cx});
    yi1   <= $signed({req.vi.dy[23], req.vi.dy}) + $signed({cy[23], cy});
    xj1   <= $signed({req.vj.dx[23], req.vj.dx}) + $signed({cx[23], cx});
    yj1   <= $signed({req.vj.dy[23], req.vj.dy}) + $signed({cy[23], cy});
  end

  // stage 2: differences
  assign px26 = $signed({{2{px[23]}}, px});
  assign py26 = $signed({{2{py[23]}}, py});
  assign cx26 = $signed({{2{cx[23]}}, cx});
  assign cy26 = $signed({{2{cy[23]}}, cy});
  assign py25 = $signed({py[23], py});

  always_comb begin
    cross_next = (yi1 > py25) != (yj1 > py25);
    if (circ1) begin
      a_next = px26 - cx26;
      d_next = px26 - cx26;
      b_next = py26 - cy26;
      c_next = py26 - cy26;
    end else begin
      a_next = px26 - $signed({xi1[24], xi1});
      d_next = $signed({yj1[24], yj1}) - $signed({yi1[24], yi1});
      b_next = $signed({xj1[24], xj1}) - $signed({xi1[24], xi1});
      c_next = py26 - $signed({yi1[24], yi1});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    circ2  <= circ1;
    cross2 <= cross_next;
    a2     <= a_next;
    b2     <= b_next;
    c2     <= c_next;
    d2     <= d_next;
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    circ3  <= circ2;
    cross3 <= cross2;
    dpos3  <= !d2[25] && (d2 != 26'sd0);
    lhs3   <= a2 * d2;
    rhs3   <= b2 * c2;
    rr3    <= radius * radius;
  end

  // stage 4: compare and accumulate
  assign sq_sum    = $signed({lhs3[51], lhs3}) + $signed({rhs3[51], rhs3});
  assign in_circle = sq_sum < $signed({7'b0, rr3});
  assign hit       = dpos3 ? (lhs3 < rhs3) : (lhs3 > rhs3);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      in_shape <= 1'b0;
    end else if (v3) begin
      if (circ3) begin
        in_shape <= in_circle;
      end else if (cross3 && hit) begin
        in_shape <= ~in_shape;
      end
    end
  end

  assign busy = v1 || v2 || v3;

endmodule

[rtl/core/point_in_shape_test_unit.sv]
// Point-in-shape test unit: top level with APB registers, vertex ring and control.
//
// The cmd channel takes one word per operation: op selects a vertex write
// (vertex_index, vertex_dx, vertex_dy) or an inside query (query_x, query_y).
// A vertex write gives no result word. A query gives one word on the res
// channel, inside_res. Vertices sit in a ring of MAX_VERTICES cells. A
// polygon query rotates the ring once, one cell per cycle, feeding one edge
// per cycle into a four-stage multiply and compare pipeline; the rotation
// always runs the full ring length, whatever the vertex count. A circle
// query skips the rotation. One query is in flight at a time: no new cmd
// word is taken until the last query has left for the output register.
// The result sits in an output register, so cmd words are taken while a
// result waits; a finished query holds until that register is free.
// Reset clears the registers and control; vertex cells are undefined until
// written. Registers are to be written over APB only while the unit is
// idle; the block itself does not enforce this.
module point_in_shape_test_unit #(
  parameter int MAX_VERTICES = psi_pkg::MaxVertices
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  psi_cmd_if.sink     cmd,
  psi_res_if.source   res
);

  localparam int StepW = $clog2(MAX_VERTICES + 2);
  localparam logic [StepW-1:0] StepLast = StepW'(MAX_VERTICES);

  localparam logic [2:0] REG_SHAPE_MODE    = 3'd0;
  localparam logic [2:0] REG_CENTER_X      = 3'd1;
  localparam logic [2:0] REG_CENTER_Y      = 3'd2;
  localparam logic [2:0] REG_SCALED_RADIUS = 3'd3;
  localparam logic [2:0] REG_VERTEX_COUNT  = 3'd4;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_QUERY     = 1'b1;
  localparam logic MODE_POLYGON = 1'b0;
  localparam logic MODE_CIRCLE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t             state;
  logic [StepW-1:0]   step;
  logic [StepW-1:0]   n_sat;
  logic [31:0]        count_wide;

  logic               shape_mode;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic [22:0]        scaled_radius;
  logic [6:0]         vertex_count;

  logic               cfg_wr;
  logic               cmd_acc, cmd_write, cmd_query;
  logic               res_valid, res_bit;

  logic signed [23:0] px, py;
  psi_pkg::vertex_t   ring [MAX_VERTICES];
  psi_pkg::vertex_t   head, prev, first, load_val;
  logic [MAX_VERTICES-1:0] wr_sel;

  logic               in_poly, shift, edge_mid, edge_close, circle_issue;
  psi_pkg::edge_req_t req;
  logic               busy, in_shape;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode    <= MODE_POLYGON;
      center_x      <= '0;
      center_y      <= '0;
      scaled_radius <= '0;
      vertex_count  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_SHAPE_MODE:    shape_mode    <= pwdata[0];
        REG_CENTER_X:      center_x      <= pwdata[23:0];
        REG_CENTER_Y:      center_y      <= pwdata[23:0];
        REG_SCALED_RADIUS: scaled_radius <= pwdata[22:0];
        REG_VERTEX_COUNT:  vertex_count  <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SHAPE_MODE:    prdata = {31'b0, shape_mode};
      REG_CENTER_X:      prdata = {8'b0, center_x};
      REG_CENTER_Y:      prdata = {8'b0, center_y};
      REG_SCALED_RADIUS: prdata = {9'b0, scaled_radius};
      REG_VERTEX_COUNT:  prdata = {25'b0, vertex_count};
      default:           prdata = '0;
    endcase
  end

  // command channel
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign cmd_write = cmd_acc && (cmd.op == OP_WRITE);
  assign cmd_query = cmd_acc && (cmd.op == OP_QUERY);
  assign load_val  = '{dx: cmd.vertex_dx, dy: cmd.vertex_dy};

  // vertex ring
  for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
    assign wr_sel[gi] = cmd_write && (32'(cmd.vertex_index) == gi);
    psi_cell u_cell (
      .clk      (clk),
      .load     (wr_sel[gi]),
      .load_val (load_val),
      .shift    (shift),
      .shift_in (ring[(gi + 1) % MAX_VERTICES]),
      .val      (ring[gi])
    );
  end

  assign head = ring[0];

  // edge sequencing
  assign count_wide = 32'(vertex_count);
  assign n_sat = (count_wide > 32'(MAX_VERTICES)) ? StepLast : StepW'(count_wide);

  assign in_poly      = (state == ST_ROTATE) && (shape_mode == MODE_POLYGON);
  assign circle_issue = (state == ST_ROTATE) && (shape_mode == MODE_CIRCLE);
  assign shift        = in_poly && (step != StepLast);
  assign edge_mid     = in_poly && (step != '0) && (step < n_sat);
  assign edge_close   = in_poly && (step == n_sat) && (n_sat != '0);

  assign req.valid  = edge_mid || edge_close || circle_issue;
  assign req.circle = (shape_mode == MODE_CIRCLE);
  assign req.vi     = edge_close ? first : head;
  assign req.vj     = prev;

  always_ff @(posedge clk) begin
    if (cmd_query) begin
      px <= {cmd.query_x, 8'b0};
      py <= {cmd.query_y, 8'b0};
    end
    if (in_poly && (step < n_sat)) begin
      prev <= head;
      if (step == '0) begin
        first <= head;
      end
    end
  end

  psi_edge_unit u_edge (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd_query),
    .req      (req),
    .px       (px),
    .py       (py),
    .cx       (center_x),
    .cy       (center_y),
    .radius   (scaled_radius),
    .busy     (busy),
    .in_shape (in_shape)
  );

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && (state != ST_FINISH)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_query) begin
            state <= ST_ROTATE;
            step  <= '0;
          end
        end
        ST_ROTATE: begin
          if (shape_mode == MODE_CIRCLE || step == StepLast) begin
            state <= ST_DRAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_bit   <= in_shape;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid      = res_valid;
  assign res.inside_res = res_bit;

endmodule

[bench/point_in_shape_test_unit_tb.sv]
// Self-checking bench for the point-in-shape unit: circle and even-odd polygon queries.
module point_in_shape_test_unit_tb;

  typedef enum logic {
    OpVertexWrite = 1'b0,
    OpQuery       = 1'b1
  } op_e;

  typedef enum int {
    RegShapeMode    = 0,
    RegCenterX      = 1,
    RegCenterY      = 2,
    RegScaledRadius = 3,
    RegVertexCount  = 4
  } reg_index_e;

  localparam int SettleCycles      = psi_pkg::MaxVertices + 16;
  localparam int WatchdogLimit     = 4000;
  localparam int BacklogHoldCycles = 400;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  psi_cmd_if cmd_if();
  psi_res_if res_if();

  point_in_shape_test_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_if),
    .res     (res_if)
  );

  logic               shadow_circle;
  logic signed [23:0] shadow_center_x;
  logic signed [23:0] shadow_center_y;
  logic        [22:0] shadow_radius;
  logic        [6:0]  shadow_vertex_count;
  psi_pkg::vertex_t   shadow_ring [psi_pkg::MaxVertices];
  logic               inside_expected_q [$];
  bit                 failed;
  bit                 steady_send;
  int                 burst_left;
  int                 res_hold_cycles;
  int                 idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int rand_center();
    return rand_between(-20000, 20000) * 256 + int'($urandom_range(0, 255));
  endfunction

  function automatic logic circle_contains(longint px, longint py);
    longint dx, dy, r;
    dx = px - longint'(shadow_center_x);
    dy = py - longint'(shadow_center_y);
    r  = longint'(shadow_radius);
    return (dx * dx + dy * dy) < r * r;
  endfunction

  function automatic logic polygon_contains(longint px, longint py);
    int     n, j;
    logic   parity;
    longint xi, yi, xj, yj, d, lhs, rhs;
    n = (shadow_vertex_count > psi_pkg::MaxVertices) ? psi_pkg::MaxVertices
                                                     : int'(shadow_vertex_count);
    parity = 1'b0;
    if (n == 0) return 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = longint'(signed'(shadow_ring[i].dx)) + longint'(shadow_center_x);
      yi = longint'(signed'(shadow_ring[i].dy)) + longint'(shadow_center_y);
      xj = longint'(signed'(shadow_ring[j].dx)) + longint'(shadow_center_x);
      yj = longint'(signed'(shadow_ring[j].dy)) + longint'(shadow_center_y);
      if ((yi > py) != (yj > py)) begin
        d   = yj - yi;
        lhs = (px - xi) * d;
        rhs = (xj - xi) * (py - yi);
        if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  task automatic send_word(op_e op, logic [5:0] slot, logic signed [23:0] dx,
                           logic signed [23:0] dy, logic signed [15:0] qx,
                           logic signed [15:0] qy);
    int     gap;
    longint px, py;
    @(negedge clk);
    if (!steady_send && burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        cmd_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    cmd_if.valid        = 1'b1;
    cmd_if.op           = op;
    cmd_if.vertex_index = slot;
    cmd_if.vertex_dx    = dx;
    cmd_if.vertex_dy    = dy;
    cmd_if.query_x      = qx;
    cmd_if.query_y      = qy;
    do @(posedge clk); while (!cmd_if.ready);
    if (op == OpVertexWrite) begin
      if (slot < psi_pkg::MaxVertices) shadow_ring[slot] = '{dx: dx, dy: dy};
    end else begin
      px = longint'(qx) * 256;
      py = longint'(qy) * 256;
      inside_expected_q.push_back(shadow_circle ? circle_contains(px, py)
                                                : polygon_contains(px, py));
    end
  endtask

  task automatic send_vertex(int slot, int dx, int dy);
    send_word(OpVertexWrite, 6'(slot), 24'(dx), 24'(dy), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_query(int qx, int qy);
    send_word(OpQuery, 6'($urandom), 24'($urandom), 24'($urandom), 16'(qx), 16'(qy));
  endtask

  // drop valid, drain results, let the ring settle
  task automatic quiesce();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (inside_expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(reg_index_e r, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 5'(4 * int'(r));
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      RegShapeMode:    shadow_circle       = value[0];
      RegCenterX:      shadow_center_x     = value[23:0];
      RegCenterY:      shadow_center_y     = value[23:0];
      RegScaledRadius: shadow_radius       = value[22:0];
      RegVertexCount:  shadow_vertex_count = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure_shape(bit circle, int cx, int cy, int radius, int count);
    quiesce();
    write_register(RegShapeMode, 32'(circle));
    write_register(RegCenterX, 32'(cx));
    write_register(RegCenterY, 32'(cy));
    write_register(RegScaledRadius, 32'(radius));
    write_register(RegVertexCount, 32'(count));
  endtask

  task automatic test_empty_polygon();
    send_query(-32768, -32768);
    send_query(32767, 32767);
    send_query(0, 0);
  endtask

  task automatic test_circle_boundary();
    configure_shape(1'b1, 0, 0, 10 * 256, 0);
    send_query(10, 0);
    send_query(9, 0);
    send_query(0, -10);
    send_query(-7, -7);
    send_query(-8, -6);
    configure_shape(1'b1, -8388608, 8388607, 8388607, 0);
    send_query(-32768, 32767);
    send_query(32767, -32768);
    configure_shape(1'b1, 0, 0, 0, 0);
    send_query(0, 0);
  endtask

  // square with fractional center; queries touch both horizontal edges
  task automatic test_square_polygon();
    configure_shape(1'b0, 384, -512, 0, 4);
    send_vertex(0, -2560, -2560);
    send_vertex(1, 2560, -2560);
    send_vertex(2, 2560, 2560);
    send_vertex(3, -2560, 2560);
    send_vertex(62, 8388607, -8388608);
    send_vertex(63, -8388608, 8388607);
    send_query(1, -2);
    send_query(12, -2);
    send_query(11, -2);
    send_query(1, -12);
    send_query(1, 8);
    send_query(-32768, -2);
  endtask

  task automatic test_fill_vertex_store();
    for (int v = 0; v < psi_pkg::MaxVertices; v++)
      send_vertex(v, int'($urandom), int'($urandom));
  endtask

  task automatic test_vertex_count_saturation();
    configure_shape(1'b0, 0, 0, 0, 127);
    repeat (4) send_query(rand_between(-32768, 32767), rand_between(-32768, 32767));
    configure_shape(1'b0, rand_center(), rand_center(), 0, psi_pkg::MaxVertices + 1);
    repeat (4) send_query(rand_between(-32768, 32767), rand_between(-32768, 32767));
  endtask

  task automatic test_random_polygons();
    int n, span, cx, cy;
    for (int phase = 0; phase < 14; phase++) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 2);
        1: n = psi_pkg::MaxVertices;
        default: n = $urandom_range(3, 10);
      endcase
      span = $urandom_range(2, 60);
      cx = rand_center();
      cy = rand_center();
      configure_shape(1'b0, cx, cy, $urandom_range(0, 8388607), n);
      for (int v = 0; v < n; v++)
        send_vertex(v, rand_between(-span * 256, span * 256),
                    rand_between(-span * 256, span * 256));
      for (int q = 0; q < 12; q++) begin
        if (n > 0 && $urandom_range(0, 7) == 0)
          send_vertex($urandom_range(0, n - 1), rand_between(-span * 256, span * 256),
                      rand_between(-span * 256, span * 256));
        send_query(rand_between((cx >>> 8) - span - 4, (cx >>> 8) + span + 4),
                   rand_between((cy >>> 8) - span - 4, (cy >>> 8) + span + 4));
      end
    end
  endtask

  task automatic test_random_circles();
    int cx, cy, radius, reach;
    for (int phase = 0; phase < 6; phase++) begin
      cx = rand_center();
      cy = rand_center();
      radius = ($urandom_range(0, 5) == 0) ? 0 : rand_between(256, 60 * 256);
      reach = (radius >>> 8) + 6;
      configure_shape(1'b1, cx, cy, radius, $urandom_range(0, 127));
      steady_send = phase[0];
      repeat (14)
        send_query(rand_between((cx >>> 8) - reach, (cx >>> 8) + reach),
                   rand_between((cy >>> 8) - reach, (cy >>> 8) + reach));
      steady_send = 1'b0;
    end
  endtask

  // hold the result side while queries keep coming so the input stalls
  task automatic test_result_backlog();
    int cx, cy;
    cx = rand_center();
    cy = rand_center();
    configure_shape(1'b1, cx, cy, 30 * 256, 0);
    res_hold_cycles = BacklogHoldCycles;
    steady_send = 1'b1;
    repeat (12)
      send_query(rand_between((cx >>> 8) - 40, (cx >>> 8) + 40),
                 rand_between((cy >>> 8) - 40, (cy >>> 8) + 40));
    steady_send = 1'b0;
  endtask

  task automatic test_noise();
    for (int round = 0; round < 2; round++) begin
      configure_shape(1'($urandom_range(0, 1)), rand_between(-8388608, 8388607),
                      rand_between(-8388608, 8388607), $urandom_range(0, 8388607),
                      $urandom_range(0, 127));
      repeat (15) begin
        if ($urandom_range(0, 1) == 0)
          send_vertex($urandom_range(0, psi_pkg::MaxVertices - 1), int'($urandom),
                      int'($urandom));
        else
          send_query(rand_between(-32768, 32767), rand_between(-32768, 32767));
      end
    end
  endtask

  initial begin : result_sink
    int style, span;
    res_if.ready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 160);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        if (res_hold_cycles > 0) begin
          res_if.ready = 1'b0;
          res_hold_cycles--;
        end else begin
          case (style)
            0: res_if.ready = 1'b1;
            1: res_if.ready = 1'($urandom_range(0, 1));
            2: res_if.ready = ($urandom_range(0, 4) == 0);
            default: res_if.ready = (c % 3 != 2);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (inside_expected_q.size() == 0) begin
        $error("inside_res: expected none, actual %0b", res_if.inside_res);
        failed = 1'b1;
      end else begin
        want = inside_expected_q.pop_front();
        if (res_if.inside_res !== want) begin
          $error("inside_res: expected %0b, actual %0b", want, res_if.inside_res);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cmd_if.valid        = 1'b0;
    cmd_if.op           = OpQuery;
    cmd_if.vertex_index = '0;
    cmd_if.vertex_dx    = '0;
    cmd_if.vertex_dy    = '0;
    cmd_if.query_x      = '0;
    cmd_if.query_y      = '0;
    shadow_circle       = 1'b0;
    shadow_center_x     = '0;
    shadow_center_y     = '0;
    shadow_radius       = '0;
    shadow_vertex_count = '0;
    failed              = 1'b0;
    steady_send         = 1'b0;
    burst_left          = 0;
    res_hold_cycles     = 0;
    idle_cycles         = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_empty_polygon();
    test_circle_boundary();
    test_square_polygon();
    test_fill_vertex_store();
    test_vertex_count_saturation();
    test_random_polygons();
    test_random_circles();
    test_result_backlog();
    test_noise();
    quiesce();

    if (!failed && inside_expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[point_in_shape_test_unit.f]
rtl/core/psi_pkg.sv
rtl/core/psi_if.sv
rtl/core/psi_cell.sv
rtl/core/psi_edge_unit.sv
rtl/core/point_in_shape_test_unit.sv
bench/point_in_shape_test_unit_tb.sv
